FILE: rtl/tse_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp text parser package
// Shared record type, error codes and small calendar tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_INVALID  = 2'd1;
  localparam logic [1:0] ERR_POINT    = 2'd2;
  localparam logic [1:0] ERR_FRACTION = 2'd3;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] fraction;
    logic [2:0]  frac_digits;
    logic [1:0]  code;
  } tse_rec_t;

  function automatic logic [19:0] pad_scale(input logic [2:0] digits);
    logic [19:0] s;
    unique case (digits)
      3'd0:    s = 20'd1000000;
      3'd1:    s = 20'd100000;
      3'd2:    s = 20'd10000;
      3'd3:    s = 20'd1000;
      3'd4:    s = 20'd100;
      3'd5:    s = 20'd10;
      default: s = 20'd1;
    endcase
    return s;
  endfunction

  function automatic logic [8:0] month_base(input logic [3:0] month);
    logic [8:0] b;
    unique case (month)
      4'd3:    b = 9'd0;
      4'd4:    b = 9'd31;
      4'd5:    b = 9'd61;
      4'd6:    b = 9'd92;
      4'd7:    b = 9'd122;
      4'd8:    b = 9'd153;
      4'd9:    b = 9'd184;
      4'd10:   b = 9'd214;
      4'd11:   b = 9'd245;
      4'd12:   b = 9'd275;
      4'd1:    b = 9'd306;
      4'd2:    b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tse_front.sv
// ----------------------------------------------------------------------------
// Timestamp character parser
// Takes one character per cycle while take is high, checks the format and
// accumulates the fields. The last one emits a record with its error code.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        text_byte,
  input  wire logic              last_byte,
  output logic                   push,
  output tse_pkg::tse_rec_t      rec
);
  import tse_pkg::*;

  localparam logic [4:0] POS_SAT = 5'd27;

  logic [4:0]  pos, pos_next;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next;
  logic [6:0]  day, day_next;
  logic [6:0]  hour, hour_next;
  logic [6:0]  minute, minute_next;
  logic [6:0]  second, second_next;
  logic [19:0] fraction, fraction_next;
  logic [2:0]  fdigits, fdigits_next;
  logic [2:0]  flags, flags_next;
  logic        is_digit;
  logic [3:0]  dg;
  logic        invalid;

  function automatic logic [6:0] step7(input logic [6:0] a, input logic [3:0] d);
    logic [10:0] t;
    t = {4'd0, a} * 11'd10 + {7'd0, d};
    return t[6:0];
  endfunction

  function automatic logic [13:0] step14(input logic [13:0] a, input logic [3:0] d);
    logic [17:0] t;
    t = {4'd0, a} * 18'd10 + {14'd0, d};
    return t[13:0];
  endfunction

  function automatic logic [19:0] step20(input logic [19:0] a, input logic [3:0] d);
    logic [23:0] t;
    t = {4'd0, a} * 24'd10 + {20'd0, d};
    return t[19:0];
  endfunction

  assign is_digit = (text_byte >= 8'd48) && (text_byte <= 8'd57);
  assign dg       = 4'(text_byte - 8'd48);

  always_comb begin
    year_next     = year;
    month_next    = month;
    day_next      = day;
    hour_next     = hour;
    minute_next   = minute;
    second_next   = second;
    fraction_next = fraction;
    fdigits_next  = fdigits;
    flags_next    = flags;
    priority if (pos <= 5'd3) begin
      if (is_digit) year_next = step14(year, dg);
      else flags_next[0] = 1'b1;
    end else if (pos == 5'd4 || pos == 5'd7) begin
      if (text_byte != 8'd45) flags_next[0] = 1'b1;
    end else if (pos == 5'd5 || pos == 5'd6) begin
      if (is_digit) month_next = step7(month, dg);
      else flags_next[0] = 1'b1;
    end else if (pos == 5'd8 || pos == 5'd9) begin
      if (is_digit) day_next = step7(day, dg);
      else flags_next[0] = 1'b1;
    end else if (pos == 5'd10) begin
      if (text_byte != 8'd32 && text_byte != 8'd84) flags_next[0] = 1'b1;
    end else if (pos == 5'd11 || pos == 5'd12) begin
      if (is_digit) hour_next = step7(hour, dg);
      else flags_next[0] = 1'b1;
    end else if (pos == 5'd13 || pos == 5'd16) begin
      if (text_byte != 8'd58) flags_next[0] = 1'b1;
    end else if (pos == 5'd14 || pos == 5'd15) begin
      if (is_digit) minute_next = step7(minute, dg);
      else flags_next[0] = 1'b1;
    end else if (pos == 5'd17 || pos == 5'd18) begin
      if (is_digit) second_next = step7(second, dg);
      else flags_next[0] = 1'b1;
    end else if (pos == 5'd19) begin
      if (text_byte != 8'd46) flags_next[1] = 1'b1;
    end else if (pos <= 5'd25) begin
      if (is_digit) begin
        fraction_next = step20(fraction, dg);
        fdigits_next  = fdigits + 3'd1;
      end else begin
        flags_next[2] = 1'b1;
      end
    end else begin
      flags_next[2] = 1'b1;
    end
    pos_next = (pos < POS_SAT) ? pos + 5'd1 : POS_SAT;
  end

  assign invalid = flags_next[0] || (pos < 5'd18) ||
                   (month_next < 7'd1) || (month_next > 7'd12) ||
                   (day_next < 7'd1) || (day_next > 7'd31) ||
                   (hour_next > 7'd23) || (minute_next > 7'd59) ||
                   (second_next > 7'd59);

  always_comb begin
    rec.year        = year_next;
    rec.month       = month_next[3:0];
    rec.day         = day_next[4:0];
    rec.hour        = hour_next[4:0];
    rec.minute      = minute_next[5:0];
    rec.second      = second_next[5:0];
    rec.fraction    = fraction_next;
    rec.frac_digits = fdigits_next;
    priority if (invalid) rec.code = ERR_INVALID;
    else if (flags_next[1]) rec.code = ERR_POINT;
    else if (flags_next[2]) rec.code = ERR_FRACTION;
    else rec.code = ERR_NONE;
  end

  assign push = take && last_byte;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos      <= '0;
      year     <= '0;
      month    <= '0;
      day      <= '0;
      hour     <= '0;
      minute   <= '0;
      second   <= '0;
      fraction <= '0;
      fdigits  <= '0;
      flags    <= '0;
    end else if (take) begin
      pos      <= pos_next;
      year     <= year_next;
      month    <= month_next;
      day      <= day_next;
      hour     <= hour_next;
      minute   <= minute_next;
      second   <= second_next;
      fraction <= fraction_next;
      fdigits  <= fdigits_next;
      flags    <= flags_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tse_queue.sv
// ----------------------------------------------------------------------------
// Parsed record queue
// Two-entry queue that decouples the character parser from the calendar
// arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tse_pkg::tse_rec_t wr_rec,
  output logic                   full,
  input  wire logic              pop,
  output logic                   avail,
  output tse_pkg::tse_rec_t      rd_rec
);
  import tse_pkg::*;

  tse_rec_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign avail  = (count != 2'd0);
  assign rd_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_rec;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tse_back.sv
// ----------------------------------------------------------------------------
// Calendar conversion unit
// Turns one parsed record into signed microseconds since 1970 over a short
// sequence of steps and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              avail,
  input  wire tse_pkg::tse_rec_t q_rec,
  output logic                   pop,
  output logic signed [58:0]     epoch_micros,
  output logic [1:0]             error_code,
  output logic                   result_valid,
  input  wire logic              result_stall
);
  import tse_pkg::*;

  localparam logic [36:0] DAY_MICROS = 37'd86400000000;
  localparam logic [16:0] C_HI = DAY_MICROS[36:20];
  localparam logic [19:0] C_LO = DAY_MICROS[19:0];

  typedef enum logic [3:0] {
    S_IDLE, S_ERA, S_YOE, S_DOE, S_DAYS, S_MHI, S_MLO, S_SUM, S_DONE
  } state_t;

  state_t              state;
  tse_rec_t            rec;
  logic signed [14:0]  y;
  logic signed [5:0]   era;
  logic [8:0]          yoe;
  logic [8:0]          doy;
  logic [17:0]         doe;
  logic signed [22:0]  days;
  logic [16:0]         tod;
  logic [19:0]         frac_pad;
  logic [36:0]         tod_us;
  logic signed [40:0]  hi_prod;
  logic signed [58:0]  lo_sum;
  logic signed [58:0]  res;

  logic signed [14:0]  y_c;
  logic [26:0]         era_prod;
  logic signed [5:0]   era_c;
  logic [39:0]         frac_prod;
  logic signed [14:0]  yoe_full;
  logic [1:0]          div100;
  logic signed [40:0]  days_w41;
  logic signed [58:0]  days_w59;

  assign pop = (state == S_IDLE) && avail;

  always_comb begin
    y_c       = $signed({1'b0, rec.year}) - ((rec.month <= 4'd2) ? 15'sd1 : 15'sd0);
    era_prod  = 27'(y_c[13:0]) * 27'd5243;
    era_c     = y_c[14] ? -6'sd1 : $signed(era_prod[26:21]);
    frac_prod = 40'(rec.fraction) * 40'(pad_scale(rec.frac_digits));
    yoe_full  = y - $signed({{9{era[5]}}, era}) * 15'sd400;
    if (yoe >= 9'd300) div100 = 2'd3;
    else if (yoe >= 9'd200) div100 = 2'd2;
    else if (yoe >= 9'd100) div100 = 2'd1;
    else div100 = 2'd0;
    days_w41  = {{18{days[22]}}, days};
    days_w59  = {{36{days[22]}}, days};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            rec <= q_rec;
            res <= '0;
            state <= (q_rec.code != ERR_NONE) ? S_DONE : S_ERA;
          end
        end
        S_ERA: begin
          y        <= y_c;
          era      <= era_c;
          frac_pad <= frac_prod[19:0];
          tod      <= 17'(rec.hour) * 17'd3600 + 17'(rec.minute) * 17'd60 +
                      17'(rec.second);
          state    <= S_YOE;
        end
        S_YOE: begin
          yoe    <= yoe_full[8:0];
          doy    <= month_base(rec.month) + 9'(rec.day) - 9'd1;
          tod_us <= 37'(tod) * 37'd1000000 + 37'(frac_pad);
          state  <= S_DOE;
        end
        S_DOE: begin
          doe   <= 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(div100) + 18'(doy);
          state <= S_DAYS;
        end
        S_DAYS: begin
          days  <= $signed({{17{era[5]}}, era}) * 23'sd146097 +
                   $signed({5'd0, doe}) - 23'sd719468;
          state <= S_MHI;
        end
        S_MHI: begin
          hi_prod <= days_w41 * $signed({24'd0, C_HI});
          state   <= S_MLO;
        end
        S_MLO: begin
          lo_sum <= days_w59 * $signed({39'd0, C_LO}) + $signed({22'd0, tod_us});
          state  <= S_SUM;
        end
        S_SUM: begin
          res   <= $signed({hi_prod[38:0], 20'd0}) + lo_sum;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            epoch_micros <= res;
            error_code   <= rec.code;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/timestamp_text_to_epoch_micros_top.sv
// ----------------------------------------------------------------------------
// Timestamp text to epoch microseconds
// Characters of a YYYY-MM-DD HH:MM:SS[.ffffff] string enter on the text
// channel, one per request, with last_byte set on the final character.
// Every string yields one request on the result channel: signed
// microseconds since 1970-01-01 and an error code (zero microseconds when
// the code is not zero).
// The parser takes one character per cycle unless text_stall is high. The
// last character of a string places a record in a two-entry queue; the
// conversion unit takes it through its chain of calendar and multiply steps
// into the result register. Since a valid string is at least 19 characters
// long, valid text flows at one character per cycle while results drain.
// text_stall rises only while the queue is full. When the receiver stalls,
// the result register holds its request, the conversion unit waits on it
// and the queue fills, after which text is stalled.
// Reset clears the parser, the queue and the result register; the first
// character after reset starts a new string.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_text_to_epoch_micros_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               text_valid,
  output logic                    text_stall,
  input  wire logic [7:0]         text_byte,
  input  wire logic               last_byte,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [58:0]      epoch_micros,
  output logic [1:0]              error_code
);
  import tse_pkg::*;

  logic     take;
  logic     push;
  logic     full;
  logic     pop;
  logic     avail;
  tse_rec_t wr_rec;
  tse_rec_t rd_rec;

  assign text_stall = full;
  assign take       = text_valid && !full;

  tse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .text_byte (text_byte),
    .last_byte (last_byte),
    .push      (push),
    .rec       (wr_rec)
  );

  tse_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .full   (full),
    .pop    (pop),
    .avail  (avail),
    .rd_rec (rd_rec)
  );

  tse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (avail),
    .q_rec        (rd_rec),
    .pop          (pop),
    .epoch_micros (epoch_micros),
    .error_code   (error_code),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire

FILE: verif/timestamp_text_to_epoch_micros_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp text to epoch microseconds testbench
// Feeds timestamp strings one character per request, first from a directed
// table, then as random well-formed, corrupted and noise strings, under
// phases of sender idling and receiver stalling. An in-bench parser predicts
// each result not typed in the table, and all are compared field by field in arrival order.
// ----------------------------------------------------------------------------

module timestamp_text_to_epoch_micros_top_tb;

  import tse_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_ROWS = 25;
  localparam int PHASE_BYTES = 175;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [2:0] FLAG_INVALID = 3'b001;
  localparam logic [2:0] FLAG_POINT = 3'b010;
  localparam logic [2:0] FLAG_FRACTION = 3'b100;

  typedef logic [7:0] char_q_t [$];

  typedef struct {
    logic signed [58:0] micros;
    logic [1:0] code;
  } stamp_t;

  typedef struct {
    string text;
    bit typed;
    logic signed [58:0] micros;
    logic [1:0] code;
  } stamp_row_t;

  typedef struct {
    logic [4:0] at;
    logic [13:0] year;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [19:0] frac;
    logic [2:0] digits;
    logic [2:0] flags;
  } parse_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic text_valid = 1'b0;
  logic text_stall;
  logic [7:0] text_byte = 8'd0;
  logic last_byte = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [58:0] epoch_micros;
  logic [1:0] error_code;

  parse_state_t parser;
  stamp_t expected_stamps [$];
  stamp_t oldest;
  stamp_row_t directed_rows [NUM_ROWS];
  int failures = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  timestamp_text_to_epoch_micros_top dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .epoch_micros (epoch_micros),
    .error_code   (error_code)
  );

  always #5 clk = ~clk;

  function automatic logic [13:0] take_digit(input logic [13:0] acc, input logic [7:0] ch);
    if (ch < "0" || ch > "9") begin
      parser.flags |= FLAG_INVALID;
      return acc;
    end
    return acc * 14'd10 + 14'(ch - 8'd48);
  endfunction

  function automatic longint civil_days(input longint year, input longint month,
                                        input longint day);
    longint y;
    longint era;
    longint yoe;
    longint doy;
    y = year - ((month <= 2) ? 1 : 0);
    era = ((y >= 0) ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (month + ((month > 2) ? -3 : 9)) + 2) / 5 + day - 1;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
  endfunction

  function automatic bit parse_timestamp_char(input logic [7:0] ch, input logic last,
                                              output stamp_t res);
    logic [4:0] at;
    longint days;
    longint frac_us;
    at = parser.at;
    res = '{micros: '0, code: ERR_NONE};
    case (at)
      5'd0, 5'd1, 5'd2, 5'd3: parser.year = take_digit(parser.year, ch);
      5'd4, 5'd7: if (ch != "-") parser.flags |= FLAG_INVALID;
      5'd5, 5'd6: parser.month = 7'(take_digit(14'(parser.month), ch));
      5'd8, 5'd9: parser.day = 7'(take_digit(14'(parser.day), ch));
      5'd10: if (ch != " " && ch != "T") parser.flags |= FLAG_INVALID;
      5'd11, 5'd12: parser.hour = 7'(take_digit(14'(parser.hour), ch));
      5'd13, 5'd16: if (ch != ":") parser.flags |= FLAG_INVALID;
      5'd14, 5'd15: parser.minute = 7'(take_digit(14'(parser.minute), ch));
      5'd17, 5'd18: parser.second = 7'(take_digit(14'(parser.second), ch));
      5'd19: if (ch != ".") parser.flags |= FLAG_POINT;
      5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25: begin
        if (ch < "0" || ch > "9") begin
          parser.flags |= FLAG_FRACTION;
        end else begin
          parser.frac = parser.frac * 20'd10 + 20'(ch - 8'd48);
          parser.digits = parser.digits + 3'd1;
        end
      end
      default: parser.flags |= FLAG_FRACTION;
    endcase
    parser.at = (at < 5'd27) ? at + 5'd1 : 5'd27;
    if (!last) return 1'b0;

    if (at < 5'd18) parser.flags |= FLAG_INVALID;
    if (parser.month < 7'd1 || parser.month > 7'd12 || parser.day < 7'd1 ||
        parser.day > 7'd31 || parser.hour > 7'd23 || parser.minute > 7'd59 ||
        parser.second > 7'd59) begin
      parser.flags |= FLAG_INVALID;
    end

    if (parser.flags & FLAG_INVALID) res.code = ERR_INVALID;
    else if (parser.flags & FLAG_POINT) res.code = ERR_POINT;
    else if (parser.flags & FLAG_FRACTION) res.code = ERR_FRACTION;

    if (res.code == ERR_NONE) begin
      days = civil_days(longint'(parser.year), longint'(parser.month),
                        longint'(parser.day));
      frac_us = longint'(parser.frac);
      for (int n = parser.digits; n < 6; n++) frac_us = frac_us * 10;
      res.micros = 59'(((days * 24 + longint'(parser.hour)) * 60 +
                        longint'(parser.minute)) * 60 * 1000000 +
                       longint'(parser.second) * 1000000 + frac_us);
    end
    parser = '{default: '0};
    return 1'b1;
  endfunction

  function automatic void append_decimal(inout char_q_t q, input int value, input int width);
    int div;
    div = 1;
    repeat (width - 1) div = div * 10;
    for (int k = 0; k < width; k++) begin
      q.insert(q.size(), 8'd48 + 8'((value / div) % 10));
      div = div / 10;
    end
  endfunction

  function automatic int pick_field(input int lo, input int hi);
    if ($urandom_range(99) < 90) return $urandom_range(hi, lo);
    return $urandom_range(99);
  endfunction

  function automatic char_q_t random_stamp();
    char_q_t q;
    int len;
    int keep;
    if ($urandom_range(99) < 10) begin
      len = $urandom_range(30, 1);
      repeat (len) q.insert(q.size(), 8'($urandom_range(255)));
      return q;
    end
    append_decimal(q, $urandom_range(9999), 4);
    q.insert(q.size(), "-");
    append_decimal(q, pick_field(1, 12), 2);
    q.insert(q.size(), "-");
    append_decimal(q, pick_field(1, 31), 2);
    q.insert(q.size(), $urandom_range(1) ? "T" : " ");
    append_decimal(q, pick_field(0, 23), 2);
    q.insert(q.size(), ":");
    append_decimal(q, pick_field(0, 59), 2);
    q.insert(q.size(), ":");
    append_decimal(q, pick_field(0, 59), 2);
    if ($urandom_range(99) >= 30) begin
      q.insert(q.size(), ".");
      len = ($urandom_range(99) < 8) ? $urandom_range(9, 7) : $urandom_range(6, 0);
      repeat (len) q.insert(q.size(), 8'd48 + 8'($urandom_range(9)));
    end
    if ($urandom_range(99) < 15) q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(99) < 6) begin
      keep = $urandom_range(q.size() - 1, 1);
      while (q.size() > keep) void'(q.pop_back());
    end
    return q;
  endfunction

  // Each call starts and ends at a falling edge.
  task automatic send_text(input char_q_t chars, input bit typed, input stamp_t typed_res);
    stamp_t res;
    logic last;
    for (int i = 0; i < chars.size(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        text_valid <= 1'b0;
        @(negedge clk);
      end
      last = (i == chars.size() - 1);
      text_valid <= 1'b1;
      text_byte <= chars[i];
      last_byte <= last;
      do @(posedge clk); while (text_stall);
      if (parse_timestamp_char(chars[i], last, res)) begin
        expected_stamps.insert(expected_stamps.size(), typed ? typed_res : res);
      end
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_stamps.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_stamps.size() == 0) begin
        $error("unexpected result: epoch_micros %0d error_code %0d", epoch_micros,
               error_code);
        failures++;
      end else begin
        oldest = expected_stamps.pop_front();
        if (epoch_micros !== oldest.micros) begin
          $error("epoch_micros: expected %0d, actual %0d", oldest.micros, epoch_micros);
          failures++;
        end
        if (error_code !== oldest.code) begin
          $error("error_code: expected %0d, actual %0d", oldest.code, error_code);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timestamp_text_to_epoch_micros_top: mismatch");
      $finish;
    end
  end

  initial begin
    char_q_t chars;
    stamp_t typed_res;
    int phase_bytes;
    int phase_strings;
    int idle_plan [4];
    int stall_plan [4];
    idle_plan = '{0, 69, 0, 38};
    stall_plan = '{0, 0, 69, 38};
    parser = '{default: '0};
    directed_rows = '{
      '{"1970-01-01 00:00:00", 1'b1, 59'sd0, ERR_NONE},
      '{"0000-01-01 00:00:00", 1'b1, -59'sd62167219200000000, ERR_NONE},
      '{"9999-12-31T23:59:59.999999", 1'b1, 59'sd253402300799999999, ERR_NONE},
      '{"1969-12-31 23:59:59.999999", 1'b1, -59'sd1, ERR_NONE},
      '{"1970-01-01 00:00:00.", 1'b1, 59'sd0, ERR_NONE},
      '{"1970-01-01T00:00:00.5", 1'b1, 59'sd500000, ERR_NONE},
      '{"2000-02-29T12:34:56.123", 1'b0, 59'sd0, ERR_NONE},
      '{"1900-03-01 07:08:09.04", 1'b0, 59'sd0, ERR_NONE},
      '{"2400-02-29 18:00:01", 1'b0, 59'sd0, ERR_NONE},
      '{"1970-01-01 00:00", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970-01-01 00:00:0", 1'b1, 59'sd0, ERR_INVALID},
      '{"Z", 1'b1, 59'sd0, ERR_INVALID},
      '{"19a0-01-01 00:00:00", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970/01-01 00:00:00", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970-01-01X00:00:00", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970-13-01 00:00:00", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970-00-01 00:00:00", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970-01-32 00:00:00", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970-01-01 24:00:00", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970-01-01 00:60:00", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970-01-01 00:00:60", 1'b1, 59'sd0, ERR_INVALID},
      '{"1970-01-01 00:00:00,5", 1'b1, 59'sd0, ERR_POINT},
      '{"1970-01-01 00:00:00.12a", 1'b1, 59'sd0, ERR_FRACTION},
      '{"1970-01-01 00:00:00.123456789", 1'b1, 59'sd0, ERR_FRACTION},
      '{"1970-13-01 00:00:00,1234567", 1'b1, 59'sd0, ERR_INVALID}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      chars.delete();
      for (int i = 0; i < directed_rows[r].text.len(); i++) begin
        chars.insert(chars.size(), directed_rows[r].text[i]);
      end
      typed_res = '{micros: directed_rows[r].micros, code: directed_rows[r].code};
      send_text(chars, directed_rows[r].typed, typed_res);
    end

    for (int phase = 0; phase < 4; phase++) begin
      text_valid <= 1'b0;
      wait_drained();
      idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      phase_bytes = 0;
      phase_strings = 0;
      while (phase_bytes < PHASE_BYTES || phase_strings < 8) begin
        chars = random_stamp();
        send_text(chars, 1'b0, typed_res);
        phase_bytes += chars.size();
        phase_strings++;
      end
    end
    text_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_stamps.size() != 0) failures++;
    if (failures == 0) begin
      $display("timestamp_text_to_epoch_micros_top: match");
    end else begin
      $display("timestamp_text_to_epoch_micros_top: mismatch");
    end
    $finish;
  end

endmodule
